[design/dse_pkg.sv]
`default_nettype none
package dse_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int IDX_W       = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = 13;
    localparam int DATA_W      = 32;
    localparam int ERR_W       = 31;
    localparam int SUM_W       = 43;
    localparam int SQ_W        = 58;
    localparam int PROD_W      = 2 * ERR_W;
    localparam int DIV_W       = 58;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
    localparam int ROOT_W      = 64;
    localparam int BIT_IDX_W   = 5;
    localparam int QDEPTH      = 4;
    localparam int Q_PTR_W     = $clog2(QDEPTH);
    localparam int Q_CNT_W     = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W   = 1;

    localparam int P95_NUM     = 19;
    localparam int P95_OFF     = 10;
    // floor(x / 20) as (x * P95_RECIP) >> P95_SHIFT, exact for x below 2^18
    localparam int P95_RECIP   = 104858;
    localparam int P95_SHIFT   = 21;
    localparam int KX_W        = 17;
    localparam int KPROD_W     = 2 * KX_W;

    localparam logic [ERR_W-1:0] ERR_MAX     = {ERR_W{1'b1}};
    localparam logic [ERR_W-1:0] BAND_RESET  = ERR_W'(65536);

    localparam logic [CFG_IDX_W-1:0] REG_SIGN_EPS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_BAND = 1'b1;

    typedef struct packed {
        logic [ERR_W-1:0] err;
        logic             mismatch;
        logic             near;
        logic             finite;
        logic             last;
    } dse_item_t;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_START,
        ST_DIV_MEAN,
        ST_DIV_MSQ,
        ST_SQRT,
        ST_SEL,
        ST_DONE
    } dse_state_t;

endpackage
`default_nettype wire

[design/dse_sample_if.sv]
`default_nettype none
interface dse_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] ref_distance;
    logic signed [31:0] cmp_distance;
    logic               both_finite;
    logic               last_sample;

    modport source (output valid, ref_distance, cmp_distance, both_finite, last_sample,
                    input ready);
    modport sink   (input valid, ref_distance, cmp_distance, both_finite, last_sample,
                    output ready);
endinterface
`default_nettype wire

[design/dse_report_if.sv]
`default_nettype none
interface dse_report_if;
    logic        valid;
    logic        ready;
    logic [12:0] n_samples;
    logic [30:0] err_max;
    logic [30:0] err_mean;
    logic [30:0] err_rms;
    logic [30:0] err_p95;
    logic [12:0] mismatch_count;
    logic [12:0] near_surface_mismatch_count;
    logic        no_samples;
    logic        store_overflow;

    modport source (output valid, n_samples, err_max, err_mean, err_rms,
                    err_p95, mismatch_count, near_surface_mismatch_count,
                    no_samples, store_overflow, input ready);
    modport sink   (input valid, n_samples, err_max, err_mean, err_rms,
                    err_p95, mismatch_count, near_surface_mismatch_count,
                    no_samples, store_overflow, output ready);
endinterface
`default_nettype wire

[design/dse_front.sv]
`default_nettype none
module dse_front
    import dse_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    dse_sample_if.sink                samples,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ERR_W-1:0]     cfg_data,
    input  wire logic                 pop,
    output dse_item_t                 head,
    output logic                      empty
);

    logic [ERR_W-1:0]   eps_reg;
    logic [ERR_W-1:0]   band_reg;
    dse_item_t          q_reg [QDEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] fill_reg;

    logic signed [DATA_W:0] diff;
    logic [DATA_W:0]        diff_mag;
    logic [DATA_W-1:0]      ref_mag;
    logic [DATA_W-1:0]      cmp_mag;
    logic                   push;
    dse_item_t              item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg  <= '0;
            band_reg <= BAND_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SIGN_EPS:  eps_reg  <= cfg_data;
                REG_NEAR_BAND: band_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // classify the beat: saturated error, sign test and near-band test
    always_comb
    begin
        diff     = (DATA_W+1)'(samples.cmp_distance) - (DATA_W+1)'(samples.ref_distance);
        diff_mag = diff[DATA_W] ? (DATA_W+1)'(-diff) : (DATA_W+1)'(diff);
        ref_mag  = samples.ref_distance[DATA_W-1] ? DATA_W'(-samples.ref_distance)
                                                  : DATA_W'(samples.ref_distance);
        cmp_mag  = samples.cmp_distance[DATA_W-1] ? DATA_W'(-samples.cmp_distance)
                                                  : DATA_W'(samples.cmp_distance);
        item.err      = (diff_mag > (DATA_W+1)'(ERR_MAX)) ? ERR_MAX : diff_mag[ERR_W-1:0];
        item.mismatch = (ref_mag > DATA_W'(eps_reg)) && (cmp_mag > DATA_W'(eps_reg))
                        && (samples.ref_distance[DATA_W-1] != samples.cmp_distance[DATA_W-1]);
        item.near     = ref_mag <= DATA_W'(band_reg);
        item.finite   = samples.both_finite;
        item.last     = samples.last_sample;
    end

    assign samples.ready = (fill_reg != Q_CNT_W'(QDEPTH));
    assign push          = samples.valid && samples.ready;
    assign empty         = (fill_reg == '0);
    assign head          = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fill_reg <= fill_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
        end
    end

endmodule
`default_nettype wire

[design/dse_back.sv]
`default_nettype none
module dse_back
    import dse_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  dse_item_t      head,
    input  wire logic      empty,
    output logic           pop,
    dse_report_if.source   report
);

    dse_state_t state_reg, state_next;

    logic [ERR_W-1:0] mem [MAX_SAMPLES];
    logic [ERR_W-1:0] rd_data_reg;

    // accumulate pipeline
    logic              hold_reg;
    logic              s1_valid_reg;
    dse_item_t         s1_reg;
    logic [PROD_W-1:0] s1_prod_reg;

    logic [CNT_W-1:0] count_reg;
    logic [ERR_W-1:0] max_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic [CNT_W-1:0] mis_reg;
    logic [CNT_W-1:0] near_reg;
    logic             ovf_reg;

    // shared divider
    logic [DIV_W-1:0]     quo_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     den_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [CNT_W:0]       trial;
    logic                 div_done;

    // percentile rank
    logic [KX_W-1:0]    kx_reg;
    logic [KPROD_W-1:0] k_prod;

    // square root
    logic [ROOT_W-1:0] sx_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] rbit_reg;
    logic [ROOT_W-1:0] rtry;

    // selection
    logic [BIT_IDX_W-1:0] b_reg;
    logic [ERR_W-1:0]     prefix_reg;
    logic [CNT_W-1:0]     k_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     rd_idx_reg;
    logic                 rd_vld_reg;
    logic [DATA_W-1:0]    hi_mask;
    logic                 hit;
    logic                 pass_done;
    logic                 take_one;
    logic [ERR_W-1:0]     prefix_next;

    logic [ERR_W-1:0] mean_reg;
    logic [ERR_W-1:0] rms_reg;

    logic             s2_last;
    logic             out_valid_reg;

    assign pop      = (state_reg == ST_ACC) && !empty && !hold_reg;
    assign s2_last  = s1_valid_reg && s1_reg.last;
    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign div_done = (div_cnt_reg == '0);
    assign rtry     = root_reg + rbit_reg;
    assign k_prod   = KPROD_W'(kx_reg) * KPROD_W'(P95_RECIP);

    assign hi_mask     = ~((DATA_W'(2) << b_reg) - DATA_W'(1));
    assign hit         = ((rd_data_reg & hi_mask[ERR_W-1:0]) == (prefix_reg & hi_mask[ERR_W-1:0]))
                         && !rd_data_reg[b_reg];
    assign pass_done   = (rd_idx_reg == count_reg) && !rd_vld_reg;
    assign take_one    = (k_reg >= cnt_reg);
    assign prefix_next = take_one ? (prefix_reg | (ERR_W'(1) << b_reg)) : prefix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_ACC;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACC:      if (s2_last) state_next = ST_START;
            ST_START:    state_next = (count_reg == '0) ? ST_DONE : ST_DIV_MEAN;
            ST_DIV_MEAN: if (div_done) state_next = ST_DIV_MSQ;
            ST_DIV_MSQ:  if (div_done) state_next = ST_SQRT;
            ST_SQRT:     if (rbit_reg == '0) state_next = ST_SEL;
            ST_SEL:      if (pass_done && b_reg == '0) state_next = ST_DONE;
            ST_DONE:     if (!out_valid_reg) state_next = ST_ACC;
            default:     state_next = ST_ACC;
        endcase
    end

    // store write during accumulation, read during selection
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ACC && s1_valid_reg && s1_reg.finite
            && count_reg != CNT_W'(MAX_SAMPLES))
            mem[count_reg[IDX_W-1:0]] <= s1_reg.err;
        rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_reg      <= head;
            s1_prod_reg <= PROD_W'(head.err) * PROD_W'(head.err);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            count_reg    <= '0;
            max_reg      <= '0;
            sum_reg      <= '0;
            sq_reg       <= '0;
            mis_reg      <= '0;
            near_reg     <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (state_reg == ST_ACC)
        begin
            s1_valid_reg <= pop;
            if (pop && head.last)
                hold_reg <= 1'b1;
            if (s1_valid_reg && s1_reg.finite)
            begin
                if (count_reg == CNT_W'(MAX_SAMPLES))
                    ovf_reg <= 1'b1;
                else
                begin
                    count_reg <= count_reg + 1'b1;
                    if (s1_reg.err > max_reg)
                        max_reg <= s1_reg.err;
                    sum_reg <= sum_reg + SUM_W'(s1_reg.err);
                    sq_reg  <= sq_reg + SQ_W'(s1_prod_reg >> 16);
                    if (s1_reg.mismatch)
                    begin
                        mis_reg <= mis_reg + 1'b1;
                        if (s1_reg.near)
                            near_reg <= near_reg + 1'b1;
                    end
                end
            end
        end
        else if (state_reg == ST_DONE && !out_valid_reg)
        begin
            // report taken into the output register, start a fresh batch
            hold_reg  <= 1'b0;
            count_reg <= '0;
            max_reg   <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            mis_reg   <= '0;
            near_reg  <= '0;
            ovf_reg   <= 1'b0;
        end
    end

    // report datapath: divides, root, bitwise selection
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_START:
            begin
                quo_reg     <= DIV_W'(sum_reg);
                rem_reg     <= '0;
                den_reg     <= count_reg;
                div_cnt_reg <= DIV_CNT_W'(DIV_W);
                mean_reg    <= '0;
                rms_reg     <= '0;
                prefix_reg  <= '0;
                kx_reg      <= KX_W'(P95_NUM) * KX_W'(count_reg - 1'b1) + KX_W'(P95_OFF);
            end
            ST_DIV_MEAN, ST_DIV_MSQ:
            begin
                if (!div_done)
                begin
                    if (trial >= {1'b0, den_reg})
                    begin
                        rem_reg <= CNT_W'(trial - {1'b0, den_reg});
                        quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial[CNT_W-1:0];
                        quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                end
                else
                begin
                    rem_reg     <= '0;
                    div_cnt_reg <= DIV_CNT_W'(DIV_W);
                    if (state_reg == ST_DIV_MEAN)
                    begin
                        mean_reg <= quo_reg[ERR_W-1:0];
                        quo_reg  <= DIV_W'(sq_reg);
                    end
                    else
                    begin
                        sx_reg   <= {quo_reg[ROOT_W-17:0], 16'd0};
                        k_reg    <= k_prod[P95_SHIFT +: CNT_W];
                        root_reg <= '0;
                        rbit_reg <= ROOT_W'(1) << (ROOT_W - 2);
                    end
                end
            end
            ST_SQRT:
            begin
                if (rbit_reg != '0)
                begin
                    if (sx_reg >= rtry)
                    begin
                        sx_reg   <= sx_reg - rtry;
                        root_reg <= (root_reg >> 1) + rbit_reg;
                    end
                    else
                        root_reg <= root_reg >> 1;
                    rbit_reg <= rbit_reg >> 2;
                end
                else
                begin
                    rms_reg    <= (root_reg[ROOT_W-1:ERR_W] != '0) ? ERR_MAX
                                                                   : root_reg[ERR_W-1:0];
                    b_reg      <= BIT_IDX_W'(ERR_W - 1);
                    cnt_reg    <= '0;
                    rd_idx_reg <= '0;
                    rd_vld_reg <= 1'b0;
                end
            end
            ST_SEL:
            begin
                if (pass_done)
                begin
                    // one bit of the order statistic settled per pass
                    prefix_reg <= prefix_next;
                    if (take_one)
                        k_reg <= k_reg - cnt_reg;
                    b_reg      <= b_reg - 1'b1;
                    cnt_reg    <= '0;
                    rd_idx_reg <= '0;
                end
                else
                begin
                    rd_vld_reg <= (rd_idx_reg != count_reg);
                    if (rd_idx_reg != count_reg)
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    if (rd_vld_reg && hit)
                        cnt_reg <= cnt_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_DONE && !out_valid_reg)
            out_valid_reg <= 1'b1;
        else if (report.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && !out_valid_reg)
        begin
            report.n_samples                   <= count_reg;
            report.err_max                     <= max_reg;
            report.err_mean                    <= mean_reg;
            report.err_rms                     <= rms_reg;
            report.err_p95                     <= prefix_reg;
            report.mismatch_count              <= mis_reg;
            report.near_surface_mismatch_count <= near_reg;
            report.no_samples                  <= (count_reg == '0);
            report.store_overflow              <= ovf_reg;
        end
    end

    assign report.valid = out_valid_reg;

endmodule
`default_nettype wire

[design/distance_error_statistics.sv]
`default_nettype none
// channel   | dir | beat contents
// samples   | in  | ref_distance, cmp_distance, both_finite, last_sample
// report    | out | count, max, mean, rms, p95, mismatch counts, flags
// cfg       | in  | write enable, index, 31-bit data (no read-back)
// a sample beat is taken each cycle while the 4-entry queue has room; the back end
// retires one queued beat a cycle into the sums and the error store while accumulating
// a last beat starts the report: two divides (mean, mean square), a square
// root and 31 passes over the n stored errors, one store read a cycle
// sampling stalls only when the queue fills during a report; no clearing pass after reset
module distance_error_statistics
    import dse_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    dse_sample_if.sink                samples,
    dse_report_if.source              report,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ERR_W-1:0]     cfg_data
);

    dse_item_t head;
    logic      empty;
    logic      pop;

    dse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    dse_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .report (report)
    );

endmodule
`default_nettype wire
